// ===== rtl/baro_temp_compensation_unit_defines.svh =====
// Assertion macros shared by the compensation unit RTL.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef BARO_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_TEMP_COMPENSATION_UNIT_DEFINES_SVH

// Check a condition in the same cycle.
`define BTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the next cycle.
`define BTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/btc_pkg.sv =====
// Types and constants of the barometric compensation unit.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none
package btc_pkg;

  localparam int QW = 37;
  localparam int RW = 40;
  localparam int NW = 76;

  localparam logic [35:0] QUOT_LIMIT = 36'hF_FFFF_FFFF;

  localparam logic [1:0] REG_TEMP_CAL = 2'd0;
  localparam logic [1:0] REG_PRES_CAL_A = 2'd1;
  localparam logic [1:0] REG_PRES_CAL_B = 2'd2;
  localparam logic [1:0] REG_PRES_CAL_C = 2'd3;

  typedef struct packed {
    logic [15:0] p9;
    logic [15:0] p8;
    logic [15:0] p7;
    logic [15:0] p6;
    logic [15:0] p5;
    logic [15:0] p4;
    logic [15:0] p3;
    logic [15:0] p2;
    logic [15:0] p1;
    logic [15:0] t3;
    logic [15:0] t2;
    logic [15:0] t1;
  } btc_cal_t;

  typedef struct packed {
    logic          valid;
    logic          inval;
    logic          sign;
    logic          sat;
    logic [15:0]   tc;
    logic [RW-1:0] ad;
    logic [RW-1:0] rem;
    logic [QW-1:0] lo;
  } btc_div_word_t;

endpackage
`default_nettype wire

// ===== rtl/btc_div_cell.sv =====
// One restoring division cell: one quotient bit per cycle while en is high.
// Depends on btc_pkg for the division word type.
`default_nettype none
module btc_div_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire btc_pkg::btc_div_word_t word_i,
  output btc_pkg::btc_div_word_t     word_o
);

  btc_pkg::btc_div_word_t word_r, word_nxt;
  logic [btc_pkg::RW:0]   trial;
  logic [btc_pkg::RW:0]   diff;
  logic                   ge;

  always_comb begin
    trial = {word_i.rem, word_i.lo[btc_pkg::QW-1]};
    diff = trial - {1'b0, word_i.ad};
    ge = trial >= {1'b0, word_i.ad};
    word_nxt = word_i;
    word_nxt.rem = ge ? diff[btc_pkg::RW-1:0] : trial[btc_pkg::RW-1:0];
    word_nxt.lo = {word_i.lo[btc_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r.valid <= word_nxt.valid;
    end
    if (en) begin
      word_r.inval <= word_nxt.inval;
      word_r.sign <= word_nxt.sign;
      word_r.sat <= word_nxt.sat;
      word_r.tc <= word_nxt.tc;
      word_r.ad <= word_nxt.ad;
      word_r.rem <= word_nxt.rem;
      word_r.lo <= word_nxt.lo;
    end
  end

  assign word_o = word_r;

endmodule
`default_nettype wire

// ===== rtl/btc_front.sv =====
// Temperature compensation and pressure divisor and dividend stages.
// Depends on btc_pkg; feeds the first division cell.
`default_nettype none
module btc_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire btc_pkg::btc_cal_t     cal,
  input  wire logic                  in_valid,
  input  wire logic [19:0]           in_raw_temperature,
  input  wire logic [19:0]           in_raw_pressure,
  output btc_pkg::btc_div_word_t     word_o
);

  logic [8:1] v_r;

  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] s1_m1_r, s1_sq_r;
  logic [19:0]        s1_rp_r;

  logic signed [22:0] s2_f1_r;
  logic signed [37:0] s2_m2_r;
  logic [19:0]        s2_rp_r;

  logic signed [24:0] s3_fine_r, s3_fine_nxt;
  logic [19:0]        s3_rp_r;

  logic signed [27:0] t5;
  logic signed [19:0] tcf;
  logic [15:0]        tc_nxt;
  logic signed [25:0] a_nxt, s4_a_r;
  logic signed [51:0] s4_aa_r;
  logic [15:0]        s4_tc_r;
  logic [19:0]        s4_rp_r;

  logic signed [67:0] s5_x6_r, s5_x3_r;
  logic signed [41:0] s5_x5_r, s5_x2_r;
  logic [15:0]        s5_tc_r;
  logic [19:0]        s5_rp_r;

  logic signed [67:0] x5e, p4e, b_nxt, s6_b_r;
  logic signed [59:0] x2e, x3s, top_nxt, s6_top_r;
  logic [15:0]        s6_tc_r;
  logic [19:0]        s6_rp_r;

  logic signed [67:0] nm, s7_n_r;
  logic signed [76:0] s7_prod_r;
  logic [15:0]        s7_tc_r;

  logic signed [43:0] div, div_abs;
  logic signed [67:0] n_abs;
  logic [btc_pkg::RW-1:0] s8_ad_r;
  logic [btc_pkg::NW-1:0] s8_num_r;
  logic               s8_sign_r, s8_inval_r;
  logic [15:0]        s8_tc_r;

  logic [38:0]        hi;
  logic               sat;
  btc_pkg::btc_div_word_t word_r, word_nxt;

  assign d1 = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign d2 = $signed({1'b0, in_raw_temperature[19:4]}) - $signed({1'b0, cal.t1});

  assign s3_fine_nxt = $signed(s2_f1_r) + $signed(s2_m2_r[37:14]);

  always_comb begin
    t5 = s3_fine_r * 28'sd5 + 28'sd128;
    tcf = $signed(t5[27:8]);
    if (tcf > 20'sd32767) begin
      tc_nxt = 16'h7FFF;
    end else if (tcf < -20'sd32768) begin
      tc_nxt = 16'h8000;
    end else begin
      tc_nxt = tcf[15:0];
    end
    a_nxt = s3_fine_r - 26'sd128000;
  end

  always_comb begin
    x5e = s5_x5_r;
    p4e = $signed(cal.p4);
    b_nxt = s5_x6_r + (x5e <<< 17) + (p4e <<< 35);
    x2e = s5_x2_r;
    x3s = $signed(s5_x3_r[67:8]);
    top_nxt = x3s + (x2e <<< 12) + 60'sh8000_0000_0000;
    nm = {16'b0, 21'h100000 - {1'b0, s6_rp_r}, 31'b0};
  end

  always_comb begin
    div = $signed(s7_prod_r[76:33]);
    div_abs = div[43] ? -div : div;
    n_abs = s7_n_r[67] ? -s7_n_r : s7_n_r;
  end

  always_comb begin
    hi = s8_num_r[btc_pkg::NW-1:btc_pkg::QW];
    sat = {1'b0, hi} >= s8_ad_r;
    word_nxt.valid = v_r[8];
    word_nxt.inval = s8_inval_r;
    word_nxt.sign = s8_sign_r;
    word_nxt.sat = sat;
    word_nxt.tc = s8_tc_r;
    word_nxt.ad = s8_ad_r;
    word_nxt.rem = sat ? '0 : {1'b0, hi};
    word_nxt.lo = s8_num_r[btc_pkg::QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      word_r.valid <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[7:1], in_valid};
      word_r.valid <= word_nxt.valid;
    end
    if (en) begin
      word_r.inval <= word_nxt.inval;
      word_r.sign <= word_nxt.sign;
      word_r.sat <= word_nxt.sat;
      word_r.tc <= word_nxt.tc;
      word_r.ad <= word_nxt.ad;
      word_r.rem <= word_nxt.rem;
      word_r.lo <= word_nxt.lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r <= d1 * $signed(cal.t2);
      s1_sq_r <= d2 * d2;
      s1_rp_r <= in_raw_pressure;

      s2_f1_r <= $signed(s1_m1_r[33:11]);
      s2_m2_r <= $signed(s1_sq_r[33:12]) * $signed(cal.t3);
      s2_rp_r <= s1_rp_r;

      s3_fine_r <= s3_fine_nxt;
      s3_rp_r <= s2_rp_r;

      s4_a_r <= a_nxt;
      s4_aa_r <= a_nxt * a_nxt;
      s4_tc_r <= tc_nxt;
      s4_rp_r <= s3_rp_r;

      s5_x6_r <= s4_aa_r * $signed(cal.p6);
      s5_x3_r <= s4_aa_r * $signed(cal.p3);
      s5_x5_r <= s4_a_r * $signed(cal.p5);
      s5_x2_r <= s4_a_r * $signed(cal.p2);
      s5_tc_r <= s4_tc_r;
      s5_rp_r <= s4_rp_r;

      s6_b_r <= b_nxt;
      s6_top_r <= top_nxt;
      s6_tc_r <= s5_tc_r;
      s6_rp_r <= s5_rp_r;

      s7_prod_r <= s6_top_r * $signed({1'b0, cal.p1});
      s7_n_r <= nm - s6_b_r;
      s7_tc_r <= s6_tc_r;

      s8_ad_r <= div_abs[btc_pkg::RW-1:0];
      s8_num_r <= btc_pkg::NW'(n_abs[63:0]) * 76'd3125;
      s8_sign_r <= s7_n_r[67] ^ div[43];
      s8_inval_r <= (div == 44'sd0);
      s8_tc_r <= s7_tc_r;
    end
  end

  assign word_o = word_r;

endmodule
`default_nettype wire

// ===== rtl/btc_back.sv =====
// Quotient saturation, pressure correction terms and output register.
// Depends on btc_pkg; takes the word leaving the last division cell.
`default_nettype none
module btc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire btc_pkg::btc_cal_t     cal,
  input  wire btc_pkg::btc_div_word_t word_i,
  output logic                       out_valid,
  output logic signed [15:0]         out_temperature_centi,
  output logic [31:0]                out_pressure_q24_8,
  output logic                       out_pressure_invalid
);

  logic [35:0]        mag;
  logic [37:0]        mag38;
  logic signed [37:0] q_c;
  logic signed [24:0] qh;

  logic               b1_v_r, b2_v_r;
  logic signed [37:0] b1_q_r, b2_q_r;
  logic signed [49:0] b1_qq_r;
  logic signed [53:0] b1_pf_r, b2_pf_r;
  logic [15:0]        b1_tc_r, b2_tc_r;
  logic               b1_inval_r, b2_inval_r;
  logic signed [65:0] b2_pe_r;

  logic signed [40:0] e;
  logic signed [34:0] f;
  logic signed [41:0] sum;
  logic signed [34:0] p7e, rr;
  logic [31:0]        pres_nxt;

  logic               out_valid_r;
  logic [15:0]        out_tc_r;
  logic [31:0]        out_pres_r;
  logic               out_inval_r;

  always_comb begin
    mag = (word_i.sat || word_i.lo[btc_pkg::QW-1]) ? btc_pkg::QUOT_LIMIT
                                                  : word_i.lo[35:0];
    mag38 = {2'b0, mag};
    q_c = word_i.sign ? $signed(-mag38) : $signed(mag38);
    qh = $signed(q_c[37:13]);
  end

  always_comb begin
    e = $signed(b2_pe_r[65:25]);
    f = $signed(b2_pf_r[53:19]);
    sum = b2_q_r + e + f;
    p7e = $signed(cal.p7);
    rr = $signed(sum[41:8]) + (p7e <<< 4);
    if (b2_inval_r || rr[34]) begin
      pres_nxt = 32'h0;
    end else if (rr[33:32] != 2'b00) begin
      pres_nxt = 32'hFFFF_FFFF;
    end else begin
      pres_nxt = rr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= word_i.valid;
      b2_v_r <= b1_v_r;
      out_valid_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_q_r <= q_c;
      b1_qq_r <= qh * qh;
      b1_pf_r <= q_c * $signed(cal.p8);
      b1_tc_r <= word_i.tc;
      b1_inval_r <= word_i.inval;

      b2_q_r <= b1_q_r;
      b2_pe_r <= b1_qq_r * $signed(cal.p9);
      b2_pf_r <= b1_pf_r;
      b2_tc_r <= b1_tc_r;
      b2_inval_r <= b1_inval_r;

      out_tc_r <= b2_tc_r;
      out_pres_r <= pres_nxt;
      out_inval_r <= b2_inval_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_temperature_centi = $signed(out_tc_r);
  assign out_pressure_q24_8 = out_pres_r;
  assign out_pressure_invalid = out_inval_r;

endmodule
`default_nettype wire

// ===== rtl/baro_temp_compensation_unit.sv =====
// Barometric temperature and pressure compensation unit, top level.
// Depends on btc_pkg, btc_front, btc_div_cell, btc_back and the defines header.
//
// Takes one word of raw 20-bit temperature and pressure readings per clock while
// in_stall is low and returns one word per reading: temperature in 0.01 degC,
// pressure in Pa as unsigned Q24.8 and a flag for a zero pressure divisor. The
// datapath is a fixed 49-stage pipeline: nine stages of temperature and divisor
// arithmetic, a row of 37 division cells that each settle one quotient bit, and
// three stages of correction terms ending in the output register. Sustained
// rate is one word per cycle while the output is not stalled.
// The whole pipeline holds while a finished word waits under out_stall.
// Write calibration registers only while no word is in flight.
`default_nettype none
`include "baro_temp_compensation_unit_defines.svh"
module baro_temp_compensation_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [19:0]        in_raw_temperature,
  input  wire logic [19:0]        in_raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_temperature_centi,
  output logic [31:0]             out_pressure_q24_8,
  output logic                    out_pressure_invalid
);

  logic [47:0] temp_cal_r;
  logic [63:0] pres_cal_a_r, pres_cal_b_r;
  logic [15:0] pres_cal_c_r;

  btc_pkg::btc_cal_t      cal;
  btc_pkg::btc_div_word_t chain [0:btc_pkg::QW];
  logic                   en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      pres_cal_a_r <= '0;
      pres_cal_b_r <= '0;
      pres_cal_c_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        btc_pkg::REG_TEMP_CAL:   temp_cal_r <= cfg_wdata[47:0];
        btc_pkg::REG_PRES_CAL_A: pres_cal_a_r <= cfg_wdata;
        btc_pkg::REG_PRES_CAL_B: pres_cal_b_r <= cfg_wdata;
        btc_pkg::REG_PRES_CAL_C: pres_cal_c_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cal = {pres_cal_c_r, pres_cal_b_r, pres_cal_a_r, temp_cal_r};

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  btc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .cal                (cal),
    .in_valid           (in_valid),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .word_o             (chain[0])
  );

  for (genvar i = 0; i < btc_pkg::QW; i++) begin : g_cell
    btc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .word_i (chain[i]),
      .word_o (chain[i+1])
    );
  end

  btc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .en                    (en),
    .cal                   (cal),
    .word_i                (chain[btc_pkg::QW]),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_q24_8    (out_pressure_q24_8),
    .out_pressure_invalid  (out_pressure_invalid)
  );

  `BTC_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid, "stalled word dropped")
  `BTC_ASSERT_NOW(a_inval_zero, out_valid && out_pressure_invalid, out_pressure_q24_8 == 32'h0, "invalid word carries pressure")
  `BTC_ASSERT_NEXT(a_no_phantom, in_valid && in_stall, $stable(chain[0].valid), "front advanced while held")

endmodule
`default_nettype wire
